>>> src/tkd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared types and constants for the three-key debounce / auto-repeat block.
// ----------------------------------------------------------------------------
package tkd_pkg;

    // key codes
    localparam logic [1:0] KEY_NONE  = 2'd0;
    localparam logic [1:0] KEY_ONE   = 2'd1;
    localparam logic [1:0] KEY_TWO   = 2'd2;
    localparam logic [1:0] KEY_THREE = 2'd3;

    // step sizes
    localparam logic [3:0] STEP_ONE  = 4'd1;
    localparam logic [3:0] STEP_FIVE = 4'd5;
    localparam logic [3:0] STEP_TEN  = 4'd10;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_BOUNCE = 2'd1;
    localparam logic [1:0] CFG_FIRST  = 2'd2;
    localparam logic [1:0] CFG_SECOND = 2'd3;

    // configuration reset values
    localparam logic       MODE_RESET   = 1'b0;
    localparam logic [7:0] BOUNCE_RESET = 8'd20;
    localparam logic [7:0] FIRST_RESET  = 8'd10;
    localparam logic [7:0] SECOND_RESET = 8'd10;

    typedef struct packed {
        logic key_one_level;
        logic key_two_level;
        logic key_three_level;
        logic clear_pending;
    } t_in_item;

    typedef struct packed {
        logic       press_pending;
        logic [1:0] key_code;
        logic [3:0] step_size;
        logic       new_press;
    } t_out_item;

    // press status shared along the key chain
    typedef struct packed {
        logic       pending;
        logic [1:0] latched;
        logic [3:0] step;
    } t_flags;

endpackage
`default_nettype wire

>>> src/tkd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkd_in_if
// Valid/ready channel carrying one tick of key pins and acknowledge.
// ----------------------------------------------------------------------------
interface tkd_in_if;
    logic               valid;
    logic               ready;
    tkd_pkg::t_in_item  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

>>> src/tkd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkd_out_if
// Valid/ready channel carrying one result per tick.
// ----------------------------------------------------------------------------
interface tkd_out_if;
    logic               valid;
    logic               ready;
    tkd_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

>>> src/tkd_plain_key.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkd_plain_key
// Normal-mode key rule: debounced release, then debounced press, blocked
// while a press is pending.
// ----------------------------------------------------------------------------
module tkd_plain_key #(
    parameter int         COUNT_WIDTH = 8,
    parameter logic [1:0] KEY_CODE    = 2'd1
) (
    input  logic                   i_pin,
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  logic [COUNT_WIDTH-1:0] i_reload,
    input  logic                   i_released,
    input  tkd_pkg::t_flags        i_flags,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic                   o_released,
    output tkd_pkg::t_flags        o_flags,
    output logic                   o_fire
);
    import tkd_pkg::*;

    logic [COUNT_WIDTH-1:0] dec_count;

    assign dec_count = i_count - COUNT_WIDTH'(1);

    always_comb begin
        o_count    = i_count;
        o_released = i_released;
        o_flags    = i_flags;
        o_fire     = 1'b0;
        if (!i_flags.pending) begin
            if (!i_pin) begin
                if (i_released) begin
                    if (dec_count == '0) begin
                        o_flags.pending = 1'b1;
                        o_flags.latched = KEY_CODE;
                        o_released      = 1'b0;
                        o_count         = i_reload;
                        o_fire          = 1'b1;
                    end else begin
                        o_count = dec_count;
                    end
                end
            end else begin
                if (dec_count == '0) begin
                    o_count    = i_reload;
                    o_released = 1'b1;
                end else begin
                    o_count = dec_count;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> src/tkd_repeat_key.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkd_repeat_key
// Continuous-mode key rule: repeat while held and advance the shared
// nested repeat counters that set the step size.
// ----------------------------------------------------------------------------
module tkd_repeat_key #(
    parameter int         COUNT_WIDTH = 8,
    parameter logic [1:0] KEY_CODE    = 2'd1
) (
    input  logic                   i_pin,
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  logic [COUNT_WIDTH-1:0] i_reload,
    input  logic [COUNT_WIDTH-1:0] i_first_reload,
    input  logic [COUNT_WIDTH-1:0] i_second_reload,
    input  logic [COUNT_WIDTH-1:0] i_inner,
    input  logic [COUNT_WIDTH-1:0] i_outer,
    input  logic                   i_released,
    input  logic                   i_held_self,
    input  logic                   i_held_other,
    input  tkd_pkg::t_flags        i_flags,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic [COUNT_WIDTH-1:0] o_inner,
    output logic [COUNT_WIDTH-1:0] o_outer,
    output logic                   o_released,
    output logic                   o_held_self,
    output tkd_pkg::t_flags        o_flags,
    output logic                   o_fire
);
    import tkd_pkg::*;

    logic [COUNT_WIDTH-1:0] dec_count;
    logic [COUNT_WIDTH-1:0] dec_inner;
    logic [COUNT_WIDTH-1:0] dec_outer;
    logic [3:0]             step_mid;

    assign dec_count = i_count - COUNT_WIDTH'(1);
    assign dec_inner = i_inner - COUNT_WIDTH'(1);
    assign dec_outer = i_outer - COUNT_WIDTH'(1);
    // the rise to five is seen by the rise to ten in the same repeat
    assign step_mid  = (i_flags.step == STEP_ONE) ? STEP_FIVE : i_flags.step;

    always_comb begin
        o_count     = i_count;
        o_inner     = i_inner;
        o_outer     = i_outer;
        o_released  = i_released;
        o_held_self = i_held_self;
        o_flags     = i_flags;
        o_fire      = 1'b0;
        if (!i_pin) begin
            if (dec_count == '0) begin
                o_flags.pending = 1'b1;
                o_flags.latched = KEY_CODE;
                o_released      = 1'b1;
                o_held_self     = 1'b1;
                o_count         = i_reload;
                o_fire          = 1'b1;
                if (dec_inner == '0) begin
                    o_inner      = i_first_reload;
                    o_flags.step = step_mid;
                    if (dec_outer == '0) begin
                        o_outer = i_second_reload;
                        if (step_mid == STEP_FIVE) begin
                            o_flags.step = STEP_TEN;
                        end
                    end else begin
                        o_outer = dec_outer;
                    end
                end else begin
                    o_inner = dec_inner;
                end
            end else begin
                o_count = dec_count;
            end
        end else begin
            o_held_self = 1'b0;
            o_count     = i_reload;
            // drop back to single steps once both keys are up
            if (!i_held_other) begin
                o_flags.step = STEP_ONE;
                o_inner      = i_first_reload;
                o_outer      = i_second_reload;
            end
        end
    end

endmodule
`default_nettype wire

>>> src/three_key_debounce_autorepeat_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_key_debounce_autorepeat_top
// Three-key debouncer with auto-repeat and step acceleration.
// ----------------------------------------------------------------------------
// Takes one tick per clock cycle and returns one result per tick. All three
// key updates run through combinational logic from the state registers
// into the result register, so a new request is taken every cycle while the
// result register is empty or being drained; a result not taken holds the
// input side until it is. Counters are COUNT_WIDTH bits wide and wrap, so
// a reload of zero means 2^COUNT_WIDTH ticks. Configuration must be written
// through the plain write port while no tick is in flight (unchecked by the
// block); a new reload value takes effect at the next reload of a counter.
module three_key_debounce_autorepeat_top #(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tkd_in_if.sink           in_ch,
    tkd_out_if.source        out_ch,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_wdata
);
    import tkd_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] BOUNCE_INIT = COUNT_WIDTH'(BOUNCE_RESET);
    localparam logic [COUNT_WIDTH-1:0] FIRST_INIT  = COUNT_WIDTH'(FIRST_RESET);
    localparam logic [COUNT_WIDTH-1:0] SECOND_INIT = COUNT_WIDTH'(SECOND_RESET);

    // configuration
    logic       r_mode;
    logic [7:0] r_bounce;
    logic [7:0] r_first;
    logic [7:0] r_second;

    // key state
    logic [COUNT_WIDTH-1:0] r_count [3];
    logic [2:0]             r_released;
    logic [1:0]             r_held;
    logic [COUNT_WIDTH-1:0] r_inner;
    logic [COUNT_WIDTH-1:0] r_outer;
    t_flags                 r_flags;

    // result register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic accept;
    logic [COUNT_WIDTH-1:0] bounce_ld;
    logic [COUNT_WIDTH-1:0] first_ld;
    logic [COUNT_WIDTH-1:0] second_ld;
    t_flags flags_clr;

    // key one
    logic [COUNT_WIDTH-1:0] p1_count, q1_count, q1_inner, q1_outer;
    logic                   p1_rel, q1_rel, q1_held, p1_fire, q1_fire;
    t_flags                 p1_flags, q1_flags;
    logic [COUNT_WIDTH-1:0] m1_count, m1_inner, m1_outer;
    logic                   m1_rel, m1_held, m1_fire;
    t_flags                 m1_flags;

    // key two
    logic [COUNT_WIDTH-1:0] p2_count, q2_count, q2_inner, q2_outer;
    logic                   p2_rel, q2_rel, q2_held, p2_fire, q2_fire;
    t_flags                 p2_flags, q2_flags;
    logic [COUNT_WIDTH-1:0] m2_count, m2_inner, m2_outer;
    logic                   m2_rel, m2_held, m2_fire;
    t_flags                 m2_flags;

    // key three
    logic [COUNT_WIDTH-1:0] n_count3;
    logic                   n_rel3, fire3;
    t_flags                 n_flags;

    assign bounce_ld = COUNT_WIDTH'(r_bounce);
    assign first_ld  = COUNT_WIDTH'(r_first);
    assign second_ld = COUNT_WIDTH'(r_second);

    assign in_ch.ready = !r_out_valid || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb begin
        flags_clr = r_flags;
        if (in_ch.item.clear_pending) begin
            flags_clr.pending = 1'b0;
        end
    end

    tkd_plain_key #(.COUNT_WIDTH(COUNT_WIDTH), .KEY_CODE(KEY_ONE)) u_plain1 (
        .i_pin      (in_ch.item.key_one_level),
        .i_count    (r_count[0]),
        .i_reload   (bounce_ld),
        .i_released (r_released[0]),
        .i_flags    (flags_clr),
        .o_count    (p1_count),
        .o_released (p1_rel),
        .o_flags    (p1_flags),
        .o_fire     (p1_fire)
    );

    tkd_repeat_key #(.COUNT_WIDTH(COUNT_WIDTH), .KEY_CODE(KEY_ONE)) u_repeat1 (
        .i_pin           (in_ch.item.key_one_level),
        .i_count         (r_count[0]),
        .i_reload        (bounce_ld),
        .i_first_reload  (first_ld),
        .i_second_reload (second_ld),
        .i_inner         (r_inner),
        .i_outer         (r_outer),
        .i_released      (r_released[0]),
        .i_held_self     (r_held[0]),
        .i_held_other    (r_held[1]),
        .i_flags         (flags_clr),
        .o_count         (q1_count),
        .o_inner         (q1_inner),
        .o_outer         (q1_outer),
        .o_released      (q1_rel),
        .o_held_self     (q1_held),
        .o_flags         (q1_flags),
        .o_fire          (q1_fire)
    );

    always_comb begin
        if (r_mode) begin
            m1_count = q1_count;
            m1_inner = q1_inner;
            m1_outer = q1_outer;
            m1_rel   = q1_rel;
            m1_held  = q1_held;
            m1_flags = q1_flags;
            m1_fire  = q1_fire;
        end else begin
            m1_count = p1_count;
            m1_inner = r_inner;
            m1_outer = r_outer;
            m1_rel   = p1_rel;
            m1_held  = r_held[0];
            m1_flags = p1_flags;
            m1_fire  = p1_fire;
        end
    end

    tkd_plain_key #(.COUNT_WIDTH(COUNT_WIDTH), .KEY_CODE(KEY_TWO)) u_plain2 (
        .i_pin      (in_ch.item.key_two_level),
        .i_count    (r_count[1]),
        .i_reload   (bounce_ld),
        .i_released (r_released[1]),
        .i_flags    (m1_flags),
        .o_count    (p2_count),
        .o_released (p2_rel),
        .o_flags    (p2_flags),
        .o_fire     (p2_fire)
    );

    tkd_repeat_key #(.COUNT_WIDTH(COUNT_WIDTH), .KEY_CODE(KEY_TWO)) u_repeat2 (
        .i_pin           (in_ch.item.key_two_level),
        .i_count         (r_count[1]),
        .i_reload        (bounce_ld),
        .i_first_reload  (first_ld),
        .i_second_reload (second_ld),
        .i_inner         (m1_inner),
        .i_outer         (m1_outer),
        .i_released      (r_released[1]),
        .i_held_self     (r_held[1]),
        .i_held_other    (m1_held),
        .i_flags         (m1_flags),
        .o_count         (q2_count),
        .o_inner         (q2_inner),
        .o_outer         (q2_outer),
        .o_released      (q2_rel),
        .o_held_self     (q2_held),
        .o_flags         (q2_flags),
        .o_fire          (q2_fire)
    );

    always_comb begin
        if (r_mode) begin
            m2_count = q2_count;
            m2_inner = q2_inner;
            m2_outer = q2_outer;
            m2_rel   = q2_rel;
            m2_held  = q2_held;
            m2_flags = q2_flags;
            m2_fire  = q2_fire;
        end else begin
            m2_count = p2_count;
            m2_inner = m1_inner;
            m2_outer = m1_outer;
            m2_rel   = p2_rel;
            m2_held  = r_held[1];
            m2_flags = p2_flags;
            m2_fire  = p2_fire;
        end
    end

    // key three follows the normal rule in both modes
    tkd_plain_key #(.COUNT_WIDTH(COUNT_WIDTH), .KEY_CODE(KEY_THREE)) u_plain3 (
        .i_pin      (in_ch.item.key_three_level),
        .i_count    (r_count[2]),
        .i_reload   (bounce_ld),
        .i_released (r_released[2]),
        .i_flags    (m2_flags),
        .o_count    (n_count3),
        .o_released (n_rel3),
        .o_flags    (n_flags),
        .o_fire     (fire3)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RESET;
            r_bounce    <= BOUNCE_RESET;
            r_first     <= FIRST_RESET;
            r_second    <= SECOND_RESET;
            r_count[0]  <= BOUNCE_INIT;
            r_count[1]  <= BOUNCE_INIT;
            r_count[2]  <= BOUNCE_INIT;
            r_released  <= '0;
            r_held      <= '0;
            r_inner     <= FIRST_INIT;
            r_outer     <= SECOND_INIT;
            r_flags     <= '{pending: 1'b0, latched: KEY_NONE, step: STEP_ONE};
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODE:   r_mode   <= i_cfg_wdata[0];
                    CFG_BOUNCE: r_bounce <= i_cfg_wdata;
                    CFG_FIRST:  r_first  <= i_cfg_wdata;
                    CFG_SECOND: r_second <= i_cfg_wdata;
                    default:    ;
                endcase
            end
            if (accept) begin
                r_count[0] <= m1_count;
                r_count[1] <= m2_count;
                r_count[2] <= n_count3;
                r_released <= {n_rel3, m2_rel, m1_rel};
                r_held     <= {m2_held, m1_held};
                r_inner    <= m2_inner;
                r_outer    <= m2_outer;
                r_flags    <= n_flags;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item.press_pending <= n_flags.pending;
            r_out_item.key_code      <= n_flags.latched;
            r_out_item.step_size     <= n_flags.step;
            r_out_item.new_press     <= m1_fire || m2_fire || fire3;
        end
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.item  = r_out_item;

    a_step_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flags.step == STEP_ONE) || (r_flags.step == STEP_FIVE) ||
        (r_flags.step == STEP_TEN))
        else $error("step size left the set one, five, ten");

    a_pending_has_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.pending |-> (r_flags.latched != KEY_NONE))
        else $error("pending press without a latched key");

    a_new_implies_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.new_press) |-> r_out_item.press_pending)
        else $error("new press reported without pending press");

    a_normal_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_mode && !i_cfg_we) |=> $stable(r_flags.step))
        else $error("step size changed in normal mode");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted request produced no result");

endmodule
`default_nettype wire
